// ===== design/ked_pkg.sv =====
// Shared types and constants of the key event detector.
`timescale 1ns / 1ps

package ked_pkg;

    localparam int PIN_W      = 4;
    localparam int KEY_W      = 2;
    localparam int FLAG_W     = 6;
    localparam int SAMPLE_W   = 8;
    localparam int TIMER_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 8;

    localparam logic [SAMPLE_W-1:0] SAMPLE_PERIOD_RST = 8'd20;
    localparam logic [TIMER_W-1:0]  LONG_PRESS_RST    = 16'd1000;
    localparam logic [TIMER_W-1:0]  REPEAT_RST        = 16'd100;

    // flag bit positions
    localparam int F_HOLD   = 0;
    localparam int F_DOWN   = 1;
    localparam int F_UP     = 2;
    localparam int F_SINGLE = 3;
    localparam int F_LONG   = 4;
    localparam int F_REPEAT = 5;

    localparam logic [FLAG_W-1:0] MASK_HOLD_ONLY = 6'h01;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_CHECK = 1'b1
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_PERIOD = 2'd0,
        CFG_LONG_PRESS    = 2'd1,
        CFG_REPEAT        = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [TIMER_W-1:0] long_press_ticks;
        logic [TIMER_W-1:0] repeat_ticks;
    } lane_cfg_t;

    typedef struct packed {
        logic              tick;
        logic              resample;
        logic              check;
        logic [KEY_W-1:0]  key_index;
        logic [FLAG_W-1:0] mask;
    } lane_ctrl_t;

endpackage

// ===== design/ked_lane.sv =====
// One key lane: sampled state, press phase machine, timer and sticky flags.
`timescale 1ns / 1ps

module ked_lane import ked_pkg::*; #(
    parameter int KEY_ID = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lane_ctrl_t        ctrl,
    input  lane_cfg_t         cfg,
    input  logic              pin_pressed,
    output logic [FLAG_W-1:0] flags
);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PRESSED = 2'd1,
        PH_LONG    = 2'd2
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic               cur_reg, cur_next;
    logic               prev_reg, prev_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic [FLAG_W-1:0]  flags_reg, flags_next;

    logic [TIMER_W-1:0] timer_dec;
    logic               selected;

    assign timer_dec = (timer_reg != '0) ? timer_reg - 1'b1 : timer_reg;
    assign selected  = ctrl.check && (int'(ctrl.key_index) == KEY_ID);

    always_comb begin
        phase_next = phase_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        timer_next = timer_reg;
        flags_next = flags_reg;
        if (ctrl.tick) begin
            timer_next = timer_dec;
            if (ctrl.resample) begin
                prev_next = cur_reg;
                cur_next  = pin_pressed;
            end
            flags_next[F_HOLD] = cur_next;
            if (cur_next && !prev_next) flags_next[F_DOWN] = 1'b1;
            if (!cur_next && prev_next) flags_next[F_UP] = 1'b1;
            unique case (phase_reg)
                PH_PRESSED: begin
                    if (!cur_next) begin
                        flags_next[F_SINGLE] = 1'b1;
                        phase_next = PH_IDLE;
                    end else if (timer_dec == '0) begin
                        timer_next = cfg.repeat_ticks;
                        flags_next[F_LONG] = 1'b1;
                        phase_next = PH_LONG;
                    end
                end
                PH_LONG: begin
                    if (!cur_next) begin
                        phase_next = PH_IDLE;
                    end else if (timer_dec == TIMER_W'(1)) begin
                        flags_next[F_REPEAT] = 1'b1;
                        timer_next = cfg.repeat_ticks;
                    end
                end
                default: begin
                    if (cur_next) begin
                        timer_next = cfg.long_press_ticks;
                        phase_next = PH_PRESSED;
                    end
                end
            endcase
        end else if (selected) begin
            // clear matched flags, but leave them on a hold-only query
            if (((flags_reg & ctrl.mask) != '0) && (ctrl.mask != MASK_HOLD_ONLY)) begin
                flags_next = flags_reg & ~ctrl.mask;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            cur_reg   <= 1'b0;
            prev_reg  <= 1'b0;
            timer_reg <= '0;
            flags_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            cur_reg   <= cur_next;
            prev_reg  <= prev_next;
            timer_reg <= timer_next;
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule

// ===== design/ked_merge.sv =====
// Merge stage: picks the queried lane, forms the hit and holds the result word.
`timescale 1ns / 1ps

module ked_merge import ked_pkg::*; #(
    parameter int NUM_KEYS = 4
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             accept,
    input  logic                             is_check,
    input  logic [KEY_W-1:0]                 key_index,
    input  logic [FLAG_W-1:0]                mask,
    input  logic [NUM_KEYS-1:0][FLAG_W-1:0]  lane_flags,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic                             m_hit,
    output logic [FLAG_W-1:0]                m_flags
);

    logic              valid_reg, valid_next;
    logic              hit_reg;
    logic [FLAG_W-1:0] flags_reg;
    logic [FLAG_W-1:0] sel_flags;

    // a key outside the lanes selects nothing and reads as zero
    always_comb begin
        sel_flags = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (int'(key_index) == k) sel_flags = lane_flags[k];
        end
        if (!is_check) sel_flags = '0;
    end

    always_comb begin
        valid_next = valid_reg;
        if (accept) valid_next = 1'b1;
        else if (m_tready) valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hit_reg   <= (sel_flags & mask) != '0;
            flags_reg <= sel_flags;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_hit    = hit_reg;
    assign m_flags  = flags_reg;

endmodule

// ===== design/key_event_detector.sv =====
// Top level of the key event detector: stream ports, registers and key lanes.
`timescale 1ns / 1ps

// Push-button event detector for NUM_KEYS keys. Each tick word (tuser 0) carries
// the raw active-low pin levels; every key lane counts its timer down, resamples
// once per sample_period ticks and sets the hold level and sticky down, up,
// single, long and repeat flags. A check word (tuser 1) returns the flags of one
// key and the hit for the given mask, clearing the matched flags unless the mask
// is hold alone. Every word gives exactly one result word. A word is taken every
// cycle unless a result is stalled; its result appears in the cycle after acceptance
// in the output register, which forms the only stage between the two sides, so the
// sustained rate is one word per cycle while m_tready stays high. Keys 4 and above
// have no pin and read as released. Write the configuration registers only while idle.

module key_event_detector import ked_pkg::*; #(
    parameter int NUM_KEYS = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [3:0] pin_levels, [5:4] key_index, [11:6] flag_mask, [15:12] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [0] opcode
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] hit, [6:1] key_flags, [7] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [SAMPLE_W-1:0] sample_period_reg;
    logic [TIMER_W-1:0]  long_press_reg;
    logic [TIMER_W-1:0]  repeat_reg;
    logic [SAMPLE_W-1:0] sample_count_reg, sample_count_next;

    logic [PIN_W-1:0]   pin_levels;
    logic [KEY_W-1:0]   key_index;
    logic [FLAG_W-1:0]  flag_mask;
    logic               accept;
    logic               is_tick;
    logic               resample;
    logic [SAMPLE_W-1:0] count_inc;

    lane_ctrl_t                      ctrl;
    lane_cfg_t                       cfg;
    logic [NUM_KEYS-1:0]             pin_pressed;
    logic [NUM_KEYS-1:0][FLAG_W-1:0] lane_flags;
    logic                            out_hit;
    logic [FLAG_W-1:0]               out_flags;

    assign pin_levels = s_tdata[PIN_W-1:0];
    assign key_index  = s_tdata[PIN_W +: KEY_W];
    assign flag_mask  = s_tdata[PIN_W+KEY_W +: FLAG_W];

    assign s_tready = !m_tvalid || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_tick  = (opcode_t'(s_tuser) == OP_TICK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_period_reg <= SAMPLE_PERIOD_RST;
            long_press_reg    <= LONG_PRESS_RST;
            repeat_reg        <= REPEAT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SAMPLE_PERIOD: sample_period_reg <= cfg_wdata[SAMPLE_W-1:0];
                CFG_LONG_PRESS:    long_press_reg    <= cfg_wdata[TIMER_W-1:0];
                CFG_REPEAT:        repeat_reg        <= cfg_wdata[TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    // advance the sample counter on every tick, wrap to zero on resample
    assign count_inc = sample_count_reg + 1'b1;

    always_comb begin
        sample_count_next = sample_count_reg;
        resample          = 1'b0;
        if (accept && is_tick) begin
            if (count_inc >= sample_period_reg) begin
                sample_count_next = '0;
                resample          = 1'b1;
            end else begin
                sample_count_next = count_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= '0;
        end else begin
            sample_count_reg <= sample_count_next;
        end
    end

    assign ctrl = '{
        tick:      accept && is_tick,
        resample:  resample,
        check:     accept && !is_tick,
        key_index: key_index,
        mask:      flag_mask
    };

    assign cfg.long_press_ticks = long_press_reg;
    assign cfg.repeat_ticks     = repeat_reg;

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        if (k < PIN_W) begin : g_pin
            assign pin_pressed[k] = !pin_levels[k];
        end else begin : g_nopin
            assign pin_pressed[k] = 1'b0;
        end

        ked_lane #(
            .KEY_ID (k)
        ) u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .cfg         (cfg),
            .pin_pressed (pin_pressed[k]),
            .flags       (lane_flags[k])
        );
    end

    ked_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .is_check   (!is_tick),
        .key_index  (key_index),
        .mask       (flag_mask),
        .lane_flags (lane_flags),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_hit      (out_hit),
        .m_flags    (out_flags)
    );

    assign m_tdata = {1'b0, out_flags, out_hit};

endmodule

// ===== design/ked_check.sv =====
// Port-level checks of the key event detector and their binding.
`timescale 1ns / 1ps

module ked_check import ked_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // input side stalls only behind a stalled result
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

    // a tick word yields an all-zero result in the next cycle
    a_tick_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (opcode_t'(s_tuser) == OP_TICK)
        |=> m_tvalid && (m_tdata == '0))
        else $error("tick word gave a nonzero result");

    // a hit needs at least one flag of the key set
    a_hit_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[FLAG_W:1] != '0)
        else $error("hit without any flag set");

endmodule

bind key_event_detector ked_check u_ked_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/testbench.sv =====
// Self-checking testbench of the key event detector: directed table, then random phases.
`timescale 1ns / 1ps

module testbench;
    import ked_pkg::*;

    localparam int NKEYS           = 4;
    localparam int WORDS_PER_PHASE = 140;
    localparam int NUM_PHASES      = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int QUIET_LIMIT     = 2000;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PRESSED = 2'd1,
        PH_LONG    = 2'd2
    } key_phase_t;

    typedef enum logic {
        ROW_WORD   = 1'b0,
        ROW_CONFIG = 1'b1
    } row_kind_t;

    typedef struct packed {
        logic              hit;
        logic [FLAG_W-1:0] flags;
    } key_result_t;

    typedef struct packed {
        row_kind_t           kind;
        opcode_t             op;
        logic [PIN_W-1:0]    pins;
        logic [KEY_W-1:0]    key;
        logic [FLAG_W-1:0]   mask;
        logic                known;
        logic                hit;
        logic [FLAG_W-1:0]   flags;
        logic [SAMPLE_W-1:0] period;
        logic [TIMER_W-1:0]  long_ticks;
        logic [TIMER_W-1:0]  rep_ticks;
    } stim_row_t;

    // Ticks always answer zero; after reset every key reads clear.
    stim_row_t stim_table [$] = '{
        {ROW_WORD,   OP_CHECK, 4'hF, 2'd0, 6'h3F, 1'b1, 1'b0, 6'h00, 8'd0, 16'd0, 16'd0},
        {ROW_WORD,   OP_TICK,  4'h0, 2'd0, 6'h00, 1'b1, 1'b0, 6'h00, 8'd0, 16'd0, 16'd0},
        {ROW_WORD,   OP_CHECK, 4'hF, 2'd3, 6'h00, 1'b1, 1'b0, 6'h00, 8'd0, 16'd0, 16'd0},
        {ROW_CONFIG, OP_TICK,  4'h0, 2'd0, 6'h00, 1'b0, 1'b0, 6'h00, 8'd0, 16'd0, 16'd1},
        {ROW_WORD,   OP_TICK,  4'h0, 2'd0, 6'h00, 1'b1, 1'b0, 6'h00, 8'd0, 16'd0, 16'd0},
        {ROW_WORD,   OP_TICK,  4'h0, 2'd1, 6'h15, 1'b1, 1'b0, 6'h00, 8'd0, 16'd0, 16'd0},
        {ROW_WORD,   OP_TICK,  4'h0, 2'd2, 6'h2A, 1'b1, 1'b0, 6'h00, 8'd0, 16'd0, 16'd0},
        {ROW_WORD,   OP_CHECK, 4'hF, 2'd0, 6'h01, 1'b0, 1'b0, 6'h00, 8'd0, 16'd0, 16'd0},
        {ROW_WORD,   OP_CHECK, 4'h0, 2'd0, 6'h01, 1'b0, 1'b0, 6'h00, 8'd0, 16'd0, 16'd0},
        {ROW_WORD,   OP_CHECK, 4'hF, 2'd1, 6'h00, 1'b0, 1'b0, 6'h00, 8'd0, 16'd0, 16'd0},
        {ROW_WORD,   OP_CHECK, 4'hF, 2'd1, 6'h3F, 1'b0, 1'b0, 6'h00, 8'd0, 16'd0, 16'd0},
        {ROW_WORD,   OP_TICK,  4'hF, 2'd0, 6'h00, 1'b1, 1'b0, 6'h00, 8'd0, 16'd0, 16'd0},
        {ROW_WORD,   OP_CHECK, 4'hF, 2'd2, 6'h0C, 1'b0, 1'b0, 6'h00, 8'd0, 16'd0, 16'd0},
        {ROW_WORD,   OP_CHECK, 4'hF, 2'd3, 6'h3F, 1'b0, 1'b0, 6'h00, 8'd0, 16'd0, 16'd0},
        {ROW_CONFIG, OP_TICK,  4'h0, 2'd0, 6'h00, 1'b0, 1'b0, 6'h00,
         8'd255, 16'd65535, 16'd65535},
        {ROW_WORD,   OP_TICK,  4'hA, 2'd3, 6'h3F, 1'b1, 1'b0, 6'h00, 8'd0, 16'd0, 16'd0},
        {ROW_WORD,   OP_CHECK, 4'h0, 2'd2, 6'h2A, 1'b0, 1'b0, 6'h00, 8'd0, 16'd0, 16'd0},
        {ROW_CONFIG, OP_TICK,  4'h0, 2'd0, 6'h00, 1'b0, 1'b0, 6'h00, 8'd1, 16'd3, 16'd2},
        {ROW_WORD,   OP_TICK,  4'h5, 2'd0, 6'h00, 1'b1, 1'b0, 6'h00, 8'd0, 16'd0, 16'd0},
        {ROW_WORD,   OP_TICK,  4'h5, 2'd0, 6'h00, 1'b1, 1'b0, 6'h00, 8'd0, 16'd0, 16'd0},
        {ROW_WORD,   OP_TICK,  4'h5, 2'd0, 6'h00, 1'b1, 1'b0, 6'h00, 8'd0, 16'd0, 16'd0},
        {ROW_WORD,   OP_TICK,  4'h5, 2'd0, 6'h00, 1'b1, 1'b0, 6'h00, 8'd0, 16'd0, 16'd0},
        {ROW_WORD,   OP_TICK,  4'h5, 2'd0, 6'h00, 1'b1, 1'b0, 6'h00, 8'd0, 16'd0, 16'd0},
        {ROW_WORD,   OP_TICK,  4'h5, 2'd0, 6'h00, 1'b1, 1'b0, 6'h00, 8'd0, 16'd0, 16'd0},
        {ROW_WORD,   OP_CHECK, 4'h5, 2'd1, 6'h30, 1'b0, 1'b0, 6'h00, 8'd0, 16'd0, 16'd0},
        {ROW_WORD,   OP_TICK,  4'hF, 2'd0, 6'h00, 1'b1, 1'b0, 6'h00, 8'd0, 16'd0, 16'd0},
        {ROW_WORD,   OP_CHECK, 4'hF, 2'd3, 6'h3F, 1'b0, 1'b0, 6'h00, 8'd0, 16'd0, 16'd0}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // predictor copy of the registers and key state
    logic [SAMPLE_W-1:0] cfg_period;
    logic [TIMER_W-1:0]  cfg_long;
    logic [TIMER_W-1:0]  cfg_repeat;
    logic [SAMPLE_W-1:0] sample_cnt;
    logic [NKEYS-1:0]    is_pressed;
    logic [NKEYS-1:0]    was_pressed;
    key_phase_t          key_phase [NKEYS];
    logic [TIMER_W-1:0]  key_timer [NKEYS];
    logic [FLAG_W-1:0]   key_flags [NKEYS];

    key_result_t pending_results [$];

    int  err_count     = 0;
    int  words_sent    = 0;
    int  checks_sent   = 0;
    int  hits_seen     = 0;
    int  long_seen     = 0;
    int  repeat_seen   = 0;
    int  settings_used = 0;
    int  quiet_cycles  = 0;
    bit  tx_steady     = 1'b0;
    bit  rx_steady     = 1'b0;
    logic long_hold_req = 1'b0;

    key_event_detector #(.NUM_KEYS(NKEYS)) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic key_result_t key_model_step(opcode_t op, logic [PIN_W-1:0] pins,
            logic [KEY_W-1:0] key, logic [FLAG_W-1:0] mask);
        key_result_t res;
        logic [FLAG_W-1:0] f;
        res = '0;
        if (op == OP_TICK) begin
            for (int k = 0; k < NKEYS; k++)
                if (key_timer[k] != '0) key_timer[k] = key_timer[k] - 1'b1;
            sample_cnt = sample_cnt + 1'b1;
            if (sample_cnt >= cfg_period) begin
                sample_cnt  = '0;
                was_pressed = is_pressed;
                is_pressed  = ~pins;
            end
            for (int k = 0; k < NKEYS; k++) begin
                f = key_flags[k];
                f[F_HOLD] = is_pressed[k];
                if (is_pressed[k] && !was_pressed[k]) f[F_DOWN] = 1'b1;
                if (!is_pressed[k] && was_pressed[k]) f[F_UP] = 1'b1;
                case (key_phase[k])
                    PH_PRESSED: begin
                        if (!is_pressed[k]) begin
                            f[F_SINGLE]  = 1'b1;
                            key_phase[k] = PH_IDLE;
                        end else if (key_timer[k] == '0) begin
                            key_timer[k] = cfg_repeat;
                            f[F_LONG]    = 1'b1;
                            key_phase[k] = PH_LONG;
                        end
                    end
                    PH_LONG: begin
                        if (!is_pressed[k]) begin
                            key_phase[k] = PH_IDLE;
                        end else if (key_timer[k] == 16'd1) begin
                            f[F_REPEAT]  = 1'b1;
                            key_timer[k] = cfg_repeat;
                        end
                    end
                    default: begin
                        if (is_pressed[k]) begin
                            key_timer[k] = cfg_long;
                            key_phase[k] = PH_PRESSED;
                        end
                    end
                endcase
                key_flags[k] = f;
            end
        end else begin
            f = key_flags[key];
            res.flags = f;
            if ((f & mask) != '0) begin
                // hold alone is a level query and leaves the flags alone
                if (mask != MASK_HOLD_ONLY) key_flags[key] = f & ~mask;
                res.hit = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [FLAG_W-1:0] pick_mask();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return FLAG_W'($urandom);
        if (r < 55) return MASK_HOLD_ONLY;
        if (r < 70) return '1;
        if (r < 80) return '0;
        return FLAG_W'(1) << $urandom_range(0, FLAG_W - 1);
    endfunction

    task automatic send_word(opcode_t op, logic [PIN_W-1:0] pins, logic [KEY_W-1:0] key,
            logic [FLAG_W-1:0] mask, logic known, key_result_t typed);
        int gap;
        key_result_t res;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'd0, mask, key, pins};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        res = key_model_step(op, pins, key, mask);
        pending_results.push_back(known ? typed : res);
        words_sent++;
        if (op == OP_CHECK) checks_sent++;
    endtask

    // Drain the block, then write all three registers on consecutive edges.
    task automatic set_config(logic [SAMPLE_W-1:0] period, logic [TIMER_W-1:0] long_ticks,
            logic [TIMER_W-1:0] rep_ticks);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SAMPLE_PERIOD;
        cfg_wdata <= CFG_DATA_W'(period);
        @(posedge aclk);
        cfg_index <= CFG_LONG_PRESS;
        cfg_wdata <= long_ticks;
        @(posedge aclk);
        cfg_index <= CFG_REPEAT;
        cfg_wdata <= rep_ticks;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        cfg_period = period;
        cfg_long   = long_ticks;
        cfg_repeat = rep_ticks;
        settings_used++;
    endtask

    // result checker
    always @(posedge aclk) begin
        key_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result word 0x%02h arrived with nothing expected", m_tdata);
                err_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (m_tdata[0] !== exp_res.hit) begin
                    $error("hit mismatch: expected %0d, got %0d", exp_res.hit, m_tdata[0]);
                    err_count++;
                end
                if (m_tdata[FLAG_W:1] !== exp_res.flags) begin
                    $error("key_flags mismatch: expected 0x%02h, got 0x%02h",
                           exp_res.flags, m_tdata[FLAG_W:1]);
                    err_count++;
                end
            end
            if (m_tdata[0]) hits_seen++;
            if (m_tdata[1 + F_LONG]) long_seen++;
            if (m_tdata[1 + F_REPEAT]) repeat_seen++;
        end
    end

    // result side: random stalls, plus one long hold-off to back the block up
    initial begin : result_sink
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin : stimulus
        stim_row_t row;
        key_result_t typed;
        logic [PIN_W-1:0] held_pins;
        logic [SAMPLE_W-1:0] period;
        logic [TIMER_W-1:0] long_ticks;
        logic [TIMER_W-1:0] rep_ticks;

        cfg_period  = SAMPLE_PERIOD_RST;
        cfg_long    = LONG_PRESS_RST;
        cfg_repeat  = REPEAT_RST;
        sample_cnt  = '0;
        is_pressed  = '0;
        was_pressed = '0;
        for (int k = 0; k < NKEYS; k++) begin
            key_phase[k] = PH_IDLE;
            key_timer[k] = '0;
            key_flags[k] = '0;
        end
        held_pins = '1;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_table[i]) begin
            row = stim_table[i];
            if (row.kind == ROW_CONFIG) begin
                set_config(row.period, row.long_ticks, row.rep_ticks);
            end else begin
                typed.hit   = row.hit;
                typed.flags = row.flags;
                send_word(row.op, row.pins, row.key, row.mask, row.known, typed);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == 0) begin
                period = 8'd1;
                long_ticks = 16'd1;
                rep_ticks = 16'd2;
            end else if (ph == 5) begin
                period = 8'd255;
                long_ticks = 16'd65535;
                rep_ticks = 16'd65535;
            end else begin
                period = SAMPLE_W'($urandom_range(0, 4));
                long_ticks = TIMER_W'($urandom_range(0, 40));
                rep_ticks = TIMER_W'($urandom_range(0, 12));
            end
            set_config(period, long_ticks, rep_ticks);
            tx_steady = (ph % 3 == 1);
            rx_steady = (ph % 4 == 2);
            if (ph == 3) long_hold_req <= 1'b1;
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if ($urandom_range(0, 9) < 3) begin
                    send_word(OP_CHECK, PIN_W'($urandom), KEY_W'($urandom), pick_mask(),
                              1'b0, '0);
                end else begin
                    // hold each key steady for a while so presses run long enough
                    for (int k = 0; k < PIN_W; k++)
                        if ($urandom_range(0, 23) == 0) held_pins[k] = ~held_pins[k];
                    if ($urandom_range(0, 9) == 0)
                        send_word(OP_TICK, PIN_W'($urandom), KEY_W'($urandom),
                                  FLAG_W'($urandom), 1'b0, '0);
                    else
                        send_word(OP_TICK, held_pins, KEY_W'($urandom),
                                  FLAG_W'($urandom), 1'b0, '0);
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);

        $display("Sent %0d words (%0d flag checks, %0d hits) over %0d register settings.",
                 words_sent, checks_sent, hits_seen, settings_used);
        $display("Results showed long press %0d times and auto-repeat %0d times.",
                 long_seen, repeat_seen);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
